FILE: src/tdj_pkg.sv
// Shared types, constants and helper functions for the timestamp dejitter block.
package tdj_pkg;

	// Delta window geometry
	localparam int WINDOW_DEPTH = 50;
	localparam int MIN_FILL     = 10;
	localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
	localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);

	// Datapath widths
	localparam int TIME_W = 48;
	localparam int SIZE_W = 20;
	localparam int SUM_W  = TIME_W + FILL_W;
	localparam int DIVD_W = SUM_W + 1;
	localparam int NN_W   = 2 * FILL_W;
	localparam int ACC_W  = 128;
	localparam int LEN_W  = 53;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_TO_TIME     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_FACTOR      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_SHIFT       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEJITTER_ENABLE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RESYNC_THRESHOLD = 3'd4;

	localparam logic [47:0] RST_SIZE_TO_TIME     = 48'h0100_0000_0000;
	localparam logic [31:0] RST_TIME_FACTOR      = 32'h0100_0000;
	localparam logic [46:0] RST_RESYNC_THRESHOLD = 47'd1677722;

	// Accumulate shift codes for the shared multiplier
	localparam int SH_W = 3;
	localparam logic [SH_W-1:0] SH_0  = 3'd0;
	localparam logic [SH_W-1:0] SH_32 = 3'd1;
	localparam logic [SH_W-1:0] SH_33 = 3'd2;
	localparam logic [SH_W-1:0] SH_64 = 3'd3;
	localparam logic [SH_W-1:0] SH_96 = 3'd4;

	typedef struct packed {
		logic                     chunk_dummy;
		logic                     chunk_sync;
		logic signed [TIME_W-1:0] chunk_time;
		logic [SIZE_W-1:0]        chunk_size;
	} chunk_t;

	typedef struct packed {
		logic                     out_sync;
		logic signed [TIME_W-1:0] out_time;
		logic [SIZE_W-1:0]        out_size;
	} result_t;

	typedef struct packed {
		logic            en;
		logic            clr;
		logic            x5;
		logic [SH_W-1:0] sh;
		logic [31:0]     a;
		logic [31:0]     b;
	} mac_ctl_t;

	function automatic logic signed [63:0] sx64(input logic signed [TIME_W-1:0] x);
		return {{(64 - TIME_W){x[TIME_W-1]}}, x};
	endfunction

	function automatic logic signed [TIME_W-1:0] sat48(input logic signed [63:0] x);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = 64'sh0000_7FFF_FFFF_FFFF;
		lo = -64'sh0000_8000_0000_0000;
		if (x > hi) begin
			return hi[TIME_W-1:0];
		end else if (x < lo) begin
			return lo[TIME_W-1:0];
		end
		return x[TIME_W-1:0];
	endfunction

	function automatic logic [TIME_W-1:0] mag48(input logic signed [TIME_W-1:0] x);
		return x[TIME_W-1] ? TIME_W'(-x) : TIME_W'(x);
	endfunction

endpackage

FILE: src/timestamp_dejitter.sv
// Timestamp dejitter top level: sequencer, state and output register.
// A chunk is taken when chunk_valid is high and chunk_stall low; chunk_stall stays high
// until the chunk is finished. Dummy chunks give no transfer. When dejittering is enabled
// and the window holds more than MIN_FILL deltas, a sync chunk walks the window
// through the shared multiplier one entry at a time, then runs a bit-serial divide
// and a second read-modify-write walk when a correction applies. A finished result
// waits in an output register, and a new chunk is accepted while it waits.
module timestamp_dejitter import tdj_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  chunk_valid,
	output logic                  chunk_stall,
	input  chunk_t                chunk_data,
	output logic                  res_valid,
	input  logic                  res_stall,
	output result_t               res_data,
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_LEN0    = 5'd1;
	localparam logic [4:0] S_LEN1    = 5'd2;
	localparam logic [4:0] S_LEN2    = 5'd3;
	localparam logic [4:0] S_LEN3    = 5'd4;
	localparam logic [4:0] S_SA_RD   = 5'd5;
	localparam logic [4:0] S_SA_M0   = 5'd6;
	localparam logic [4:0] S_SA_M1   = 5'd7;
	localparam logic [4:0] S_SA_M2   = 5'd8;
	localparam logic [4:0] S_SA_DR   = 5'd9;
	localparam logic [4:0] S_SB_SAVE = 5'd10;
	localparam logic [4:0] S_SB_N    = 5'd11;
	localparam logic [4:0] S_SB_DR   = 5'd12;
	localparam logic [4:0] S_SB_SQ0  = 5'd13;
	localparam logic [4:0] S_SB_SQ1  = 5'd14;
	localparam logic [4:0] S_SB_SQ2  = 5'd15;
	localparam logic [4:0] S_SB_DR2  = 5'd16;
	localparam logic [4:0] S_SB_X5   = 5'd17;
	localparam logic [4:0] S_SB_CMP  = 5'd18;
	localparam logic [4:0] S_DIV     = 5'd19;
	localparam logic [4:0] S_SC_ADJ  = 5'd20;
	localparam logic [4:0] S_SC_RD   = 5'd21;
	localparam logic [4:0] S_SC_WR   = 5'd22;
	localparam logic [4:0] S_PUSH    = 5'd23;
	localparam logic [4:0] S_RS0     = 5'd24;
	localparam logic [4:0] S_RS1     = 5'd25;
	localparam logic [4:0] S_RS2     = 5'd26;
	localparam logic [4:0] S_RS3     = 5'd27;
	localparam logic [4:0] S_FIN     = 5'd28;

	// Configuration
	logic [47:0]              s2t_q;
	logic [31:0]              tf_q;
	logic signed [TIME_W-1:0] tsh_q;
	logic                     den_q;
	logic [46:0]              thr_q;

	// Control state
	logic [4:0]               state_q;
	logic                     locked_q;
	logic signed [TIME_W-1:0] scale_q;
	logic [FILL_W-1:0]        fill_q;
	logic [ADDR_W-1:0]        head_q;
	logic [FILL_W-1:0]        i_q;
	logic [1:0]               k_q;
	logic                     osync_q;
	logic                     raw_q;
	logic                     adv_q;
	logic                     res_valid_q;

	// Working data
	chunk_t                   item_q;
	result_t                  res_q;
	logic [LEN_W-1:0]         len_q;
	logic signed [TIME_W-1:0] psh_q;
	logic signed [TIME_W-1:0] rsrc_q;
	logic signed [TIME_W-1:0] rt_q;
	logic [ACC_W-1:0]         q_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic [SUM_W-1:0]         us_q;
	logic                     sneg_q;
	logic signed [63:0]       corr_q;

	// Unit connections
	mac_ctl_t                 mac_ctl;
	logic [ACC_W-1:0]         acc;
	logic                     win_we;
	logic [ADDR_W-1:0]        win_waddr;
	logic signed [TIME_W-1:0] win_wdata;
	logic                     win_re;
	logic [ADDR_W-1:0]        win_raddr;
	logic signed [TIME_W-1:0] win_rd;
	logic                     div_start;
	logic [DIVD_W-1:0]        div_dividend;
	logic [DIVD_W-1:0]        div_quo;
	logic                     div_done;

	// Combinational helpers
	logic [LEN_W-1:0]         len_c;
	logic signed [63:0]       t64;
	logic signed [63:0]       scale64;
	logic signed [63:0]       delta64;
	logic [63:0]              dmag;
	logic                     over;
	logic [TIME_W-1:0]        ent_m;
	logic [TIME_W-1:0]        rs_m;
	logic signed [63:0]       rr_s;
	logic signed [63:0]       rv;
	logic signed [TIME_W-1:0] rt_c;
	logic                     cmp_gt;
	logic [NN_W-1:0]          nn;
	logic signed [63:0]       corr_c;
	logic [ADDR_W-1:0]        walk_addr;
	logic [ADDR_W-1:0]        push_addr;
	logic                     can_load;

	function automatic logic [ADDR_W-1:0] win_idx(input logic [ADDR_W-1:0] h,
		input logic [FILL_W-1:0] i);
		logic [FILL_W:0] s;
		s = (FILL_W + 1)'(h) + (FILL_W + 1)'(i);
		if (s >= (FILL_W + 1)'(WINDOW_DEPTH)) begin
			s = s - (FILL_W + 1)'(WINDOW_DEPTH);
		end
		return s[ADDR_W-1:0];
	endfunction

	// Arithmetic around the shared unit
	always_comb begin
		len_c   = LEN_W'((acc + ACC_W'(32768)) >> 16);
		t64     = sx64(item_q.chunk_time);
		scale64 = sx64(scale_q);
		delta64 = t64 - scale64;
		dmag    = delta64[63] ? 64'(-delta64) : 64'(delta64);
		over    = dmag > 64'(thr_q);
		ent_m   = mag48(win_rd);
		rs_m    = mag48(rsrc_q);
		rr_s    = $signed(64'((acc + ACC_W'(8388608)) >> 24));
		rv      = rsrc_q[TIME_W-1] ? -rr_s : rr_s;
		rt_c    = sat48(rv + sx64(tsh_q));
		cmp_gt  = acc > q_q;
		nn      = NN_W'(fill_q) * NN_W'(fill_q);
		div_dividend = DIVD_W'({us_q, 1'b0}) + DIVD_W'(nn >> 1);
		corr_c  = sneg_q ? -$signed(64'(div_quo)) : $signed(64'(div_quo));
		walk_addr = win_idx(head_q, i_q);
		push_addr = (fill_q < FILL_W'(WINDOW_DEPTH)) ? win_idx(head_q, fill_q) : head_q;
		can_load  = !res_valid_q || !res_stall;
	end

	// Drive the shared multiplier
	always_comb begin
		mac_ctl     = '0;
		mac_ctl.clr = (state_q == S_IDLE) || (state_q == S_LEN3) ||
			(state_q == S_PUSH) || (state_q == S_SB_SAVE) || (state_q == S_SB_SQ0);
		mac_ctl.x5  = (state_q == S_SB_X5);
		case (state_q)
			S_LEN0: begin
				mac_ctl.en = 1'b1;
				mac_ctl.a  = 32'(item_q.chunk_size);
				mac_ctl.b  = s2t_q[31:0];
				mac_ctl.sh = SH_0;
			end
			S_LEN1: begin
				mac_ctl.en = 1'b1;
				mac_ctl.a  = 32'(item_q.chunk_size);
				mac_ctl.b  = 32'(s2t_q[47:32]);
				mac_ctl.sh = SH_32;
			end
			S_SA_M0: begin
				mac_ctl.en = 1'b1;
				mac_ctl.a  = ent_m[31:0];
				mac_ctl.b  = ent_m[31:0];
				mac_ctl.sh = SH_0;
			end
			S_SA_M1: begin
				mac_ctl.en = 1'b1;
				mac_ctl.a  = ent_m[31:0];
				mac_ctl.b  = 32'(ent_m[47:32]);
				mac_ctl.sh = SH_33;
			end
			S_SA_M2: begin
				mac_ctl.en = 1'b1;
				mac_ctl.a  = 32'(ent_m[47:32]);
				mac_ctl.b  = 32'(ent_m[47:32]);
				mac_ctl.sh = SH_64;
			end
			S_SB_N: begin
				mac_ctl.en = 1'b1;
				mac_ctl.b  = 32'(fill_q);
				case (k_q)
					2'd0: begin
						mac_ctl.a  = q_q[31:0];
						mac_ctl.sh = SH_0;
					end
					2'd1: begin
						mac_ctl.a  = q_q[63:32];
						mac_ctl.sh = SH_32;
					end
					2'd2: begin
						mac_ctl.a  = q_q[95:64];
						mac_ctl.sh = SH_64;
					end
					default: begin
						mac_ctl.a  = q_q[127:96];
						mac_ctl.sh = SH_96;
					end
				endcase
			end
			S_SB_SQ0: begin
				mac_ctl.en = 1'b1;
				mac_ctl.a  = us_q[31:0];
				mac_ctl.b  = us_q[31:0];
				mac_ctl.sh = SH_0;
			end
			S_SB_SQ1: begin
				mac_ctl.en = 1'b1;
				mac_ctl.a  = us_q[31:0];
				mac_ctl.b  = 32'(us_q[SUM_W-1:32]);
				mac_ctl.sh = SH_33;
			end
			S_SB_SQ2: begin
				mac_ctl.en = 1'b1;
				mac_ctl.a  = 32'(us_q[SUM_W-1:32]);
				mac_ctl.b  = 32'(us_q[SUM_W-1:32]);
				mac_ctl.sh = SH_64;
			end
			S_RS0: begin
				mac_ctl.en = 1'b1;
				mac_ctl.a  = rs_m[31:0];
				mac_ctl.b  = tf_q;
				mac_ctl.sh = SH_0;
			end
			S_RS1: begin
				mac_ctl.en = 1'b1;
				mac_ctl.a  = 32'(rs_m[47:32]);
				mac_ctl.b  = tf_q;
				mac_ctl.sh = SH_32;
			end
			default: begin
				mac_ctl.en = 1'b0;
			end
		endcase
	end

	// Window access
	always_comb begin
		win_re    = (state_q == S_SA_RD) || (state_q == S_SC_RD);
		win_raddr = walk_addr;
		win_we    = (state_q == S_PUSH) || (state_q == S_SC_WR);
		win_waddr = (state_q == S_PUSH) ? push_addr : walk_addr;
		win_wdata = (state_q == S_PUSH) ? psh_q : sat48(sx64(win_rd) - corr_q);
		div_start = (state_q == S_SB_CMP) && cmp_gt;
	end

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2t_q       <= RST_SIZE_TO_TIME;
			tf_q        <= RST_TIME_FACTOR;
			tsh_q       <= '0;
			den_q       <= 1'b1;
			thr_q       <= RST_RESYNC_THRESHOLD;
			state_q     <= S_IDLE;
			locked_q    <= 1'b0;
			scale_q     <= '0;
			fill_q      <= '0;
			head_q      <= '0;
			i_q         <= '0;
			k_q         <= '0;
			osync_q     <= 1'b0;
			raw_q       <= 1'b0;
			adv_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				case (cfg_idx)
					REG_SIZE_TO_TIME:     s2t_q <= cfg_data[47:0];
					REG_TIME_FACTOR:      tf_q  <= cfg_data[31:0];
					REG_TIME_SHIFT:       tsh_q <= cfg_data[47:0];
					REG_DEJITTER_ENABLE:  den_q <= cfg_data[0];
					REG_RESYNC_THRESHOLD: thr_q <= cfg_data[46:0];
					default: ;
				endcase
			end
			// Load a finished result or drop the one just transferred
			if (state_q == S_FIN && can_load) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (chunk_valid && !chunk_data.chunk_dummy) begin
						state_q <= S_LEN0;
					end
				end
				S_LEN0: state_q <= S_LEN1;
				S_LEN1: state_q <= S_LEN2;
				S_LEN2: state_q <= S_LEN3;
				S_LEN3: begin
					osync_q <= item_q.chunk_sync;
					i_q     <= '0;
					if (!item_q.chunk_sync) begin
						scale_q <= sat48(scale64 + 64'(len_c));
						raw_q   <= 1'b1;
						adv_q   <= 1'b0;
						state_q <= S_FIN;
					end else if (!locked_q) begin
						locked_q <= 1'b1;
						scale_q  <= sat48(t64 + 64'(len_c));
						raw_q    <= 1'b0;
						adv_q    <= 1'b0;
						state_q  <= S_RS0;
					end else if (den_q && over) begin
						scale_q <= item_q.chunk_time;
						fill_q  <= '0;
						head_q  <= '0;
						raw_q   <= 1'b1;
						adv_q   <= 1'b0;
						state_q <= S_FIN;
					end else if (den_q && fill_q > FILL_W'(MIN_FILL)) begin
						raw_q   <= 1'b0;
						adv_q   <= 1'b1;
						state_q <= S_SA_RD;
					end else begin
						raw_q   <= 1'b0;
						adv_q   <= 1'b1;
						state_q <= S_PUSH;
					end
				end
				S_SA_RD: state_q <= S_SA_M0;
				S_SA_M0: state_q <= S_SA_M1;
				S_SA_M1: state_q <= S_SA_M2;
				S_SA_M2: begin
					i_q <= i_q + 1'b1;
					state_q <= (i_q == fill_q - 1'b1) ? S_SA_DR : S_SA_RD;
				end
				S_SA_DR: state_q <= S_SB_SAVE;
				S_SB_SAVE: begin
					k_q     <= '0;
					state_q <= S_SB_N;
				end
				S_SB_N: begin
					k_q <= k_q + 1'b1;
					if (k_q == 2'd3) begin
						state_q <= S_SB_DR;
					end
				end
				S_SB_DR:  state_q <= S_SB_SQ0;
				S_SB_SQ0: state_q <= S_SB_SQ1;
				S_SB_SQ1: state_q <= S_SB_SQ2;
				S_SB_SQ2: state_q <= S_SB_DR2;
				S_SB_DR2: state_q <= S_SB_X5;
				S_SB_X5:  state_q <= S_SB_CMP;
				S_SB_CMP: state_q <= cmp_gt ? S_DIV : S_PUSH;
				S_DIV: begin
					if (div_done) begin
						state_q <= S_SC_ADJ;
					end
				end
				S_SC_ADJ: begin
					scale_q <= sat48(scale64 + corr_c);
					i_q     <= '0;
					state_q <= S_SC_RD;
				end
				S_SC_RD: state_q <= S_SC_WR;
				S_SC_WR: begin
					i_q <= i_q + 1'b1;
					state_q <= (i_q == fill_q - 1'b1) ? S_PUSH : S_SC_RD;
				end
				S_PUSH: begin
					if (fill_q < FILL_W'(WINDOW_DEPTH)) begin
						fill_q <= fill_q + 1'b1;
					end else if (head_q == ADDR_W'(WINDOW_DEPTH - 1)) begin
						head_q <= '0;
					end else begin
						head_q <= head_q + 1'b1;
					end
					state_q <= S_RS0;
				end
				S_RS0: state_q <= S_RS1;
				S_RS1: state_q <= S_RS2;
				S_RS2: state_q <= S_RS3;
				S_RS3: state_q <= S_FIN;
				S_FIN: begin
					if (can_load) begin
						if (adv_q) begin
							scale_q <= sat48(scale64 + 64'(len_q));
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working data registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && chunk_valid) begin
			item_q <= chunk_data;
		end
		if (state_q == S_LEN3) begin
			len_q  <= len_c;
			psh_q  <= sat48(delta64);
			rsrc_q <= item_q.chunk_time;
			sum_q  <= '0;
		end
		if (state_q == S_SA_M0) begin
			sum_q <= sum_q + {{(SUM_W - TIME_W){win_rd[TIME_W-1]}}, win_rd};
		end
		if (state_q == S_SB_SAVE) begin
			q_q    <= acc;
			us_q   <= sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
			sneg_q <= sum_q[SUM_W-1];
		end
		if (state_q == S_SB_SQ0) begin
			q_q <= acc;
		end
		if (state_q == S_SC_ADJ) begin
			corr_q <= corr_c;
		end
		if (state_q == S_PUSH) begin
			rsrc_q <= den_q ? scale_q : item_q.chunk_time;
		end
		if (state_q == S_RS3) begin
			rt_q <= rt_c;
		end
		if (state_q == S_FIN && can_load) begin
			res_q.out_sync <= osync_q;
			res_q.out_time <= raw_q ? item_q.chunk_time : rt_q;
			res_q.out_size <= item_q.chunk_size;
		end
	end

	tdj_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.acc    (acc)
	);

	tdj_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (nn),
		.quotient (div_quo),
		.done     (div_done)
	);

	tdj_win u_win (
		.clk   (clk),
		.we    (win_we),
		.waddr (win_waddr),
		.wdata (win_wdata),
		.re    (win_re),
		.raddr (win_raddr),
		.rdata (win_rd)
	);

	assign chunk_stall = (state_q != S_IDLE);
	assign res_valid   = res_valid_q;
	assign res_data    = res_q;

	// Window count never passes its depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(WINDOW_DEPTH))
		else $error("window fill beyond depth");

	// Head moves only once the window is full
	a_head_full: assert property (@(posedge clk) disable iff (!arst_n)
		head_q != '0 |-> fill_q == FILL_W'(WINDOW_DEPTH))
		else $error("window head moved before full");

	// A new result appears only from the finish step
	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q) == S_FIN)
		else $error("result raised outside finish step");

endmodule

FILE: src/tdj_mac.sv
// Shared multiply-accumulate unit: registered 32x32 product, shifted into a wide accumulator.
module tdj_mac import tdj_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  mac_ctl_t         ctl,
	output logic [ACC_W-1:0] acc
);

	logic [63:0]      prod_s1;
	logic [SH_W-1:0]  sh_s1;
	logic             vld_s1;
	logic [ACC_W-1:0] addend;
	logic [ACC_W-1:0] acc_q;

	// Track which products are waiting to be summed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= ctl.en;
		end
	end

	// Multiply stage
	always_ff @(posedge clk) begin
		prod_s1 <= ctl.a * ctl.b;
		sh_s1   <= ctl.sh;
	end

	// Align the product
	always_comb begin
		case (sh_s1)
			SH_0:    addend = ACC_W'(prod_s1);
			SH_32:   addend = ACC_W'(prod_s1) << 32;
			SH_33:   addend = ACC_W'(prod_s1) << 33;
			SH_64:   addend = ACC_W'(prod_s1) << 64;
			SH_96:   addend = ACC_W'(prod_s1) << 96;
			default: addend = ACC_W'(prod_s1);
		endcase
	end

	// Accumulate, clear or scale by five
	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			acc_q <= '0;
		end else if (ctl.x5) begin
			acc_q <= (acc_q << 2) + acc_q;
		end else if (vld_s1) begin
			acc_q <= acc_q + addend;
		end
	end

	assign acc = acc_q;

endmodule

FILE: src/tdj_div.sv
// Restoring divider, one quotient bit per cycle, for the window correction.
module tdj_div import tdj_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIVD_W-1:0] dividend,
	input  logic [NN_W-1:0]   divisor,
	output logic [DIVD_W-1:0] quotient,
	output logic              done
);

	localparam int CNT_W = $clog2(DIVD_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NN_W-1:0]  rem_q;
	logic [NN_W-1:0]  dvs_q;
	logic [DIVD_W-1:0] dq_q;
	logic [NN_W:0]    rem_sh;
	logic [NN_W:0]    rem_nx;
	logic             ge;

	// Trial subtract
	always_comb begin
		rem_sh = {rem_q, dq_q[DIVD_W-1]};
		ge     = rem_sh >= {1'b0, dvs_q};
		rem_nx = ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
	end

	// Step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dq_q  <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nx[NN_W-1:0];
			dq_q  <= {dq_q[DIVD_W-2:0], ge};
		end
	end

	assign quotient = dq_q;
	assign done     = done_q;

endmodule

FILE: src/tdj_win.sv
// Delta window storage: one write port, one registered read port.
module tdj_win import tdj_pkg::*; (
	input  logic                     clk,
	input  logic                     we,
	input  logic [ADDR_W-1:0]        waddr,
	input  logic signed [TIME_W-1:0] wdata,
	input  logic                     re,
	input  logic [ADDR_W-1:0]        raddr,
	output logic signed [TIME_W-1:0] rdata
);

	logic signed [TIME_W-1:0] mem [WINDOW_DEPTH];

	// Write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read, hold between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
